// File: src/bfba_pkg.sv
// ============================================================================
// Best-fit block allocator package
// Shared widths, codes, state encoding and controller/datapath interface types.
// ============================================================================
package bfba_pkg;

   localparam int DEFAULT_NUM_BLOCKS = 16;
   localparam int DEFAULT_SIZE_WIDTH = 16;

   // Fixed field widths of the streaming channels.
   localparam int CFG_W       = 5;
   localparam int INDEX_W     = 4;
   localparam int SIZE_IN_W   = 16;
   localparam int REMAIN_W    = 16;
   localparam int TOTAL_W     = 20;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Transaction kinds carried on req_tuser.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;    // take the request, start a new scan
      logic scan_step;  // advance the table scan by one entry
      logic finish;     // write back the grant and load the response register
   } cmd_type;

   typedef struct packed {
      logic scan_done;  // every active entry has been examined
      logic rsp_free;   // response register can take a new transaction
   } status_type;

endpackage

// File: src/bfba_datapath.sv
// ============================================================================
// Best-fit block allocator datapath
// Free-size table, scan comparator and accumulator, response register.
// ============================================================================
module bfba_datapath import bfba_pkg::*; #(
   parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS,
   parameter int SIZE_WIDTH = DEFAULT_SIZE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CFG_W-1:0]       csr_wdata,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int SUM_W = SIZE_WIDTH + CNT_W;

   logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
   logic [SIZE_WIDTH-1:0] rd_data_ff;

   logic [CFG_W-1:0]      blocks_in_use_ff;
   logic                  mode_ff;
   logic                  load_ok_ff;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic [CNT_W-1:0]      active_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  pend_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [SIZE_WIDTH-1:0] best_val_ff;
   logic                  rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [31:0]           ld_idx32;
   logic [31:0]           size32;
   logic [SIZE_WIDTH-1:0] req_size;
   logic                  req_load_ok;
   logic [CNT_W-1:0]      active_in;
   logic                  rd_en;
   logic                  candidate;
   logic                  granted;
   logic [SIZE_WIDTH-1:0] new_val;
   logic [SUM_W-1:0]      diff;
   logic [TOTAL_W-1:0]    total;
   logic [31:0]           remain32;
   logic [31:0]           chosen32;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [SIZE_WIDTH-1:0] mem_wdata;

   // Request fields: block index in the low bits, size above it.
   assign ld_idx32    = 32'(req_tdata[INDEX_W-1:0]);
   assign size32      = 32'(req_tdata[INDEX_W +: SIZE_IN_W]);
   assign req_size    = size32[SIZE_WIDTH-1:0];
   assign req_load_ok = (req_tuser == MODE_LOAD) && (ld_idx32 < 32'(NUM_BLOCKS));

   assign active_in = (32'(blocks_in_use_ff) > 32'(NUM_BLOCKS)) ?
                      CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_in_use_ff);

   assign rd_en = cmd.scan_step && (cnt_ff < active_ff);

   assign candidate = pend_ff && (mode_ff == MODE_ALLOC) && (size_ff <= rd_data_ff) &&
                      (!found_ff || (rd_data_ff < best_val_ff));

   assign granted  = (mode_ff == MODE_ALLOC) && found_ff;
   assign new_val  = best_val_ff - size_ff;
   assign diff     = sum_ff - (granted ? SUM_W'(size_ff) : SUM_W'(0));
   assign total    = (64'(diff) > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(diff);
   assign remain32 = granted ? 32'(new_val) :
                     ((mode_ff == MODE_LOAD) && load_ok_ff) ? 32'(size_ff) : 32'd0;
   assign chosen32 = granted ? 32'(best_idx_ff) : 32'd0;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = new_val;
      if (cmd.capture && req_load_ok) begin
         mem_we    = 1'b1;
         mem_waddr = ld_idx32[IDX_W-1:0];
         mem_wdata = req_size;
      end else if (cmd.finish && granted) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[cnt_ff[IDX_W-1:0]];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= '0;
         pend_ff          <= 1'b0;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wen) begin
            blocks_in_use_ff <= csr_wdata;
         end
         if (cmd.capture) begin
            cnt_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            pend_ff <= rd_en;
            if (rd_en) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and scan accumulators.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_tuser;
         load_ok_ff <= req_load_ok;
         size_ff    <= req_size;
         active_ff  <= active_in;
         sum_ff     <= '0;
         found_ff   <= 1'b0;
      end else if (cmd.scan_step) begin
         if (pend_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_data_ff);
         end
         if (candidate) begin
            found_ff    <= 1'b1;
            best_val_ff <= rd_data_ff;
            best_idx_ff <= IDX_W'(cnt_ff - CNT_W'(1));
         end
      end
      if (cmd.finish) begin
         rsp_data_ff <= {7'd0, total, remain32[REMAIN_W-1:0], chosen32[INDEX_W-1:0], granted};
      end
   end

   assign status.scan_done = (cnt_ff == active_ff) && !pend_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/bfba_controller.sv
// ============================================================================
// Best-fit block allocator controller
// Sequences capture, table scan and write-back for one transaction at a time.
// ============================================================================
module bfba_controller import bfba_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FINISH: begin
            // Wait here until the response register has room.
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

// File: src/best_fit_block_allocator.sv
// ============================================================================
// Best-fit block allocator
// Keeps a free-size table and places requests in the smallest block that fits.
// ============================================================================
//
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  tuser: mode; tdata: block index, size
// rsp_      out        rsp_tvalid/rsp_tready  tdata: grant, block, remainder, total
// csr_      in         csr_wen                blocks in use (5 bits)
//
// Each transaction scans the n blocks in use, capped at NUM_BLOCKS, reading the
// single-ported table one entry per cycle, and then loads the response
// register. The controller returns to idle at the same edge that loads the
// response register.
// A new transaction is accepted while the previous response is still waiting to
// be taken; a stalled response holds the next one in its final step.
// Reset is synchronous and clears the controller, the response valid flag and
// the blocks-in-use register. The table contents are undefined until loaded.
//
module best_fit_block_allocator import bfba_pkg::*; #(
   parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS,
   parameter int SIZE_WIDTH = DEFAULT_SIZE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration write: number of blocks taking part in allocation.
   input  logic                   csr_wen,
   input  logic [CFG_W-1:0]       csr_wdata,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [3:0] block_index, [19:4] size_value
   input  logic                   req_tuser,   // [0] mode: 0 load, 1 allocate
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [0] granted, [4:1] chosen_block,
                                               // [20:5] block_remaining, [40:21] total_free
);

   cmd_type    cmd;
   status_type status;

   // The controller only sequences; all table and arithmetic work sits in the
   // datapath, which scans the table once per transaction to find the best
   // fit and to accumulate the total free space at the same time.
   bfba_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bfba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/allocation_checker.sv
// ============================================================================
// Best-fit allocation checker
// Watches the request, response and register ports of the allocator, keeps
// its own free-size table and compares every response with the prediction.
// ============================================================================
module allocation_checker import bfba_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CFG_W-1:0]       csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     mismatch_count,
   output int                     outcomes_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = DEFAULT_NUM_BLOCKS;

   // Laid out as on rsp_tdata, granted in the lowest bit.
   typedef struct packed {
      logic [TOTAL_W-1:0]  total;
      logic [REMAIN_W-1:0] remaining;
      logic [INDEX_W-1:0]  chosen;
      logic                granted;
   } alloc_outcome_type;

   logic [SIZE_IN_W-1:0] free_size [TABLE_DEPTH];
   logic [CFG_W-1:0]     active_blocks;
   alloc_outcome_type    outcome_queue [$];
   int                   error_total = 0;

   assign mismatch_count = error_total;

   // Updates the table for one transaction and returns the response it causes.
   function automatic alloc_outcome_type allocate_best_fit(input logic mode,
                                                           input logic [INDEX_W-1:0] idx,
                                                           input logic [SIZE_IN_W-1:0] size);
      alloc_outcome_type    outcome;
      int                   active;
      int                   j;
      int                   best;
      bit                   found;
      logic [SIZE_IN_W-1:0] best_size;
      longint unsigned      sum;
      outcome   = '0;
      active    = (active_blocks > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_blocks);
      found     = 1'b0;
      best      = 0;
      best_size = '0;
      if (mode == MODE_LOAD) begin
         if (idx < TABLE_DEPTH) begin
            free_size[idx]    = size;
            outcome.remaining = size;
         end
      end else begin
         for (j = 0; j < active; j++) begin
            if (size <= free_size[j] && (!found || free_size[j] < best_size)) begin
               found     = 1'b1;
               best      = j;
               best_size = free_size[j];
            end
         end
         if (found) begin
            free_size[best]   = best_size - size;
            outcome.granted   = 1'b1;
            outcome.chosen    = best[INDEX_W-1:0];
            outcome.remaining = free_size[best];
         end
      end
      sum = 0;
      for (j = 0; j < active; j++) sum += free_size[j];
      outcome.total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      return outcome;
   endfunction

   task automatic report_field(input string name, input longint unsigned want,
                               input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin : monitor
      alloc_outcome_type got;
      alloc_outcome_type want;
      if (reset) begin
         outcome_queue.delete();
         active_blocks = '0;
         foreach (free_size[i]) free_size[i] = '0;
      end else begin
         if (csr_wen) active_blocks = csr_wdata;
         // Responses are retired before the new request is queued, so a response
         // can never be matched with the transaction accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(alloc_outcome_type)-1:0];
            if (outcome_queue.size() == 0) begin
               $error("response with no transaction outstanding: tdata %h", rsp_tdata);
               error_total++;
            end else begin
               want = outcome_queue.pop_front();
               report_field("granted", want.granted, got.granted);
               report_field("chosen_block", want.chosen, got.chosen);
               report_field("block_remaining", want.remaining, got.remaining);
               report_field("total_free", want.total, got.total);
            end
         end
         if (req_tvalid && req_tready)
            outcome_queue.push_back(allocate_best_fit(req_tuser, req_tdata[INDEX_W-1:0],
                                                      req_tdata[INDEX_W +: SIZE_IN_W]));
      end
      outcomes_pending <= outcome_queue.size();
   end

endmodule

// File: tb/testbench.sv
// ============================================================================
// Best-fit allocator testbench
// Drives load and allocate transactions under several register settings and
// handshake pressures; a separate checker predicts and compares responses.
// ============================================================================
module testbench import bfba_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int PHASE_ITEMS  = 240;
   localparam int PHASES       = 8;
   localparam int TABLE_DEPTH  = DEFAULT_NUM_BLOCKS;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_wen    = 1'b0;
   logic [CFG_W-1:0]       csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [3:0] block_index, [19:4] size_value
   logic                   req_tuser  = MODE_LOAD;   // [0] mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // [0] granted, [4:1] chosen_block,
                                       // [20:5] block_remaining, [40:21] total_free

   int mismatch_count;
   int outcomes_pending;
   int cycle_count   = 0;
   int sent_count    = 0;
   int retired_count = 0;

   // Percentages of cycles in which the sender holds back or the receiver stalls.
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;

   // The most recent size loaded; requests sometimes ask for exactly this so
   // that exact fits, which leave a block empty, turn up regularly.
   logic [SIZE_IN_W-1:0] last_loaded = '0;

   // Block sizes used by the opening loads. Block 0 holds the largest size,
   // block 1 is empty, and blocks 2 and 3 tie so that the lower index must win.
   logic [SIZE_IN_W-1:0] opening_sizes [TABLE_DEPTH] = '{
      16'hFFFF, 16'd0, 16'd100, 16'd100, 16'd50, 16'd1000, 16'd2000, 16'd4000,
      16'd300, 16'd7, 16'd65534, 16'd12345, 16'd800, 16'd1, 16'd32768, 16'd999
   };

   // Register settings for the random phases. Values above the table size
   // must behave as a full table; zero blocks in use makes every request fail.
   int phase_setting [PHASES] = '{16, 5, 31, 1, 0, 20, 12, 0};

   best_fit_block_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   allocation_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_wdata        (csr_wdata),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .outcomes_pending (outcomes_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver decides afresh at every edge whether it takes a response.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Responses taken so far; the stimulus uses this to know when the block has
   // gone quiet before a register write.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         retired_count <= retired_count + 1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Presents one transaction and waits until it is accepted. The valid flag is
   // only lowered when a gap is wanted, so it is never dropped and raised again
   // within the same time step.
   task automatic send_txn(input logic mode, input logic [INDEX_W-1:0] idx,
                           input logic [SIZE_IN_W-1:0] size);
      if (chance(sender_idle_pct)) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (chance(sender_idle_pct));
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_TDATA_W - INDEX_W - SIZE_IN_W){1'b0}}, size, idx};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Stops sending and waits for every outstanding response to be taken.
   // Each transaction yields exactly one response, so the block is idle then.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (retired_count != sent_count) @(posedge clock);
   endtask

   task automatic write_blocks_in_use(input logic [CFG_W-1:0] value);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Phases rotate through no idling, a slow sender, a slow receiver and both.
   task automatic set_pressure(input int phase);
      case (phase % 4)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 61;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 61;
         end
         default: begin
            sender_idle_pct    = 25;
            receiver_stall_pct = 25;
         end
      endcase
   endtask

   // Random traffic: mostly requests, with enough loads to keep refilling the
   // table. Loads favour moderate sizes and requests small ones, so that grants,
   // exact fits and failures all occur often.
   task automatic random_txn;
      logic [INDEX_W-1:0]   idx;
      logic [SIZE_IN_W-1:0] size;
      idx = INDEX_W'($urandom_range(TABLE_DEPTH - 1));
      if (chance(30)) begin
         case ($urandom_range(9))
            0:       size = '0;
            1:       size = '1;
            2, 3:    size = SIZE_IN_W'($urandom);
            default: size = SIZE_IN_W'($urandom_range(4095));
         endcase
         last_loaded = size;
         send_txn(MODE_LOAD, idx, size);
      end else begin
         case ($urandom_range(9))
            0:       size = '0;
            1:       size = '1;
            2:       size = last_loaded;
            3:       size = SIZE_IN_W'($urandom);
            4:       size = SIZE_IN_W'($urandom_range(4095));
            default: size = SIZE_IN_W'($urandom_range(511));
         endcase
         // The block index is ignored for requests, so it is left random.
         send_txn(MODE_ALLOC, idx, size);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Every table entry is loaded while no blocks are in use, so that neither
      // a request nor the running total can ever read an unwritten entry. With
      // a 4-bit index a load beyond the table cannot be expressed.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_txn(MODE_LOAD, i[INDEX_W-1:0], opening_sizes[i]);
      end
      // With no blocks in use even a zero-sized request must fail.
      send_txn(MODE_ALLOC, '0, '0);

      // All register bits set: more blocks than the table holds.
      write_blocks_in_use('1);
      send_txn(MODE_ALLOC, '1, '0);           // zero request: smallest block wins
      send_txn(MODE_ALLOC, '0, 16'd100);      // tie between two blocks: lower one
      send_txn(MODE_ALLOC, '0, 16'hFFFF);     // only the largest block fits
      send_txn(MODE_ALLOC, '0, 16'hFFFF);     // now nothing is that large
      send_txn(MODE_ALLOC, '0, 16'd65534);    // exact fit, leaves the block empty

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            write_blocks_in_use(CFG_W'($urandom_range(31)));
         end else begin
            write_blocks_in_use(CFG_W'(phase_setting[p]));
         end
         set_pressure(p);
         repeat (PHASE_ITEMS) random_txn();
      end

      drain();
      // A short settling period catches any stray response after the last one.
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && outcomes_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
